// File: hdl/sroc_pkg.sv
// ----------------------------------------------------------------------------
// sroc_pkg
// Shared widths, types and constants of the segment raster overlap counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sroc_pkg;

  // Coordinate of one end point
  localparam int COORD_W = 10;
  // Running overlap total
  localparam int TOTAL_W = 21;
  // Per-cell hit counter
  localparam int HITS_W  = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [HITS_W-1:0]  hits_t;

  // A cell counter stops here; reaching it marks an overlap
  localparam hits_t  HIT_LIMIT = hits_t'(2);
  localparam hits_t  HIT_ONE   = hits_t'(1);
  localparam total_t TOTAL_MAX = '1;

endpackage

`default_nettype wire

// File: hdl/segment_raster_overlap_counter_core.sv
// ----------------------------------------------------------------------------
// segment_raster_overlap_counter_core
// Rasterizes line segments into a grid of saturating hit counters and keeps
// a running count of the cells that have been hit at least twice.
// ----------------------------------------------------------------------------
// Segment channel (segment_valid / segment_stall): one segment per beat,
//   x_start, y_start, x_end, y_end. Result channel (result_valid /
//   result_stall): one beat per segment, overlap_total after drawing and
//   segment_rejected for a segment that is not horizontal, vertical or at
//   exactly 45 degrees (not drawn, total as is). Off-grid cells are skipped.
// Sequence: a drawn segment of length L (larger of |dx|, |dy|) goes through
//   setup, L+1 cell read-modify-writes (read port, then write port), drain
//   and result load once the output register is free; a rejected one skips walk and drain.
// Throughput: one segment at a time, segment_stall high until its result is
//   loaded into the output register. The cell walk sets the rate.
// Reset: rst clears the total and starts a clearing pass over the counter
//   memory, GRID_SIDE*GRID_SIDE cells, one cell a cycle, no segment taken.
// Stall: a waiting result holds in the output register; the next segment is
//   still accepted and its result waits until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_raster_overlap_counter_core #(
  parameter int GRID_SIDE = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // segment channel
  input  wire logic                        segment_valid,
  output      logic                        segment_stall,
  input  wire sroc_pkg::coord_t            x_start,
  input  wire sroc_pkg::coord_t            y_start,
  input  wire sroc_pkg::coord_t            x_end,
  input  wire sroc_pkg::coord_t            y_end,
  // result channel
  output      logic                        result_valid,
  input  wire logic                        result_stall,
  output      sroc_pkg::total_t            overlap_total,
  output      logic                        segment_rejected
);

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(GRID_SIDE + 1);
  localparam int CW     = (IDX_W > sroc_pkg::COORD_W) ? IDX_W : sroc_pkg::COORD_W;

  // sequencer codes
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  logic [2:0]        state;
  logic [AW-1:0]     clr_addr;

  sroc_pkg::coord_t  x0, y0, x1, y1;
  sroc_pkg::coord_t  col, row, remaining;
  logic              col_inc, col_dec, row_inc, row_dec;
  logic [AW-1:0]     addr, step;
  logic              rejected;
  sroc_pkg::total_t  total;

  // write-back stage
  logic              p_valid;
  logic [AW-1:0]     p_addr;
  sroc_pkg::hits_t   rdata;

  // memory port signals
  logic              rd_en, wr_en;
  logic [AW-1:0]     waddr;
  sroc_pkg::hits_t   wdata;

  // setup arithmetic
  sroc_pkg::coord_t  adx, ady, len;
  logic              x_up, x_down, y_up, y_down, oblique;
  logic [AW-1:0]     start_addr, col_step, row_step;
  logic              in_grid;
  logic              seg_beat, res_free;

  assign segment_stall = (state != ST_IDLE);
  assign seg_beat      = segment_valid && !segment_stall;
  assign res_free      = !result_valid || !result_stall;

  // direction, length and start address of the latched segment
  always_comb begin
    x_up     = (x1 > x0);
    x_down   = (x1 < x0);
    y_up     = (y1 > y0);
    y_down   = (y1 < y0);
    adx      = x_down ? (x0 - x1) : (x1 - x0);
    ady      = y_down ? (y0 - y1) : (y1 - y0);
    len      = (adx > ady) ? adx : ady;
    oblique  = (x0 != x1) && (y0 != y1) && (adx != ady);
    start_addr = AW'(AW'(x0) * AW'(GRID_SIDE)) + AW'(y0);
    col_step = x_up ? AW'(GRID_SIDE) : (x_down ? AW'(-AW'(GRID_SIDE)) : '0);
    row_step = y_up ? AW'(1) : (y_down ? '1 : '0);
  end

  // current cell lies inside the grid
  assign in_grid = (CW'(col) < CW'(GRID_SIDE)) && (CW'(row) < CW'(GRID_SIDE));

  // sequencer and cell walker
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (seg_beat) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state <= oblique ? ST_RESULT : ST_WALK;
        end
        ST_WALK: begin
          if (remaining == '0) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // segment latch and walk registers
  always_ff @(posedge clk) begin
    if (seg_beat) begin
      x0 <= x_start;
      y0 <= y_start;
      x1 <= x_end;
      y1 <= y_end;
    end
    if (state == ST_SETUP) begin
      col       <= x0;
      row       <= y0;
      remaining <= len;
      addr      <= start_addr;
      step      <= col_step + row_step;
      col_inc   <= x_up;
      col_dec   <= x_down;
      row_inc   <= y_up;
      row_dec   <= y_down;
      rejected  <= oblique;
    end else if (state == ST_WALK) begin
      col       <= col_inc ? col + 1'b1 : (col_dec ? col - 1'b1 : col);
      row       <= row_inc ? row + 1'b1 : (row_dec ? row - 1'b1 : row);
      remaining <= remaining - 1'b1;
      addr      <= addr + step;
    end
  end

  // read issue: one cell a cycle
  assign rd_en = (state == ST_WALK) && in_grid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= rd_en;
    end
    p_addr <= addr;
  end

  // write port: clearing pass or saturating increment
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      wr_en = p_valid && (rdata != sroc_pkg::HIT_LIMIT);
      waddr = p_addr;
      wdata = rdata + sroc_pkg::HIT_ONE;
    end
  end

  // counter memory
  sroc_pkg::hits_t hits_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= hits_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hits_mem[waddr] <= wdata;
    end
  end

  // running total: bump when a cell goes from one hit to two
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (p_valid && (rdata == sroc_pkg::HIT_ONE) &&
                 (total != sroc_pkg::TOTAL_MAX)) begin
      total <= total + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_RESULT && res_free) begin
      result_valid     <= 1'b1;
      overlap_total    <= total;
      segment_rejected <= rejected;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // checks
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (total >= $past(total)))
    else $error("overlap total went down");

  a_no_rmw_in_clear: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state != ST_CLEAR))
    else $error("cell update during clearing pass");

  a_hits_in_range: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (rdata != 2'd3))
    else $error("cell counter beyond saturation");

  a_result_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |=> (state == ST_RESULT) && !p_valid)
    else $error("write-back still pending at result");

endmodule

`default_nettype wire
